@@ rtl/fms_pkg.sv @@
// ----------------------------------------------------------------------------
// fms_pkg
// Shared types and constants of the flight mode supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package fms_pkg;

    // Flight modes, in the encoding shown on the mode output.
    typedef enum logic [1:0] {
        MODE_LANDED  = 2'd0,
        MODE_TAKEOFF = 2'd1,
        MODE_FLYING  = 2'd2,
        MODE_LANDING = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ALT_STEP       = 3'd0,
        CFG_ALT_MAX        = 3'd1,
        CFG_ALT_MIN_FLYING = 3'd2,
        CFG_YAW_STEP       = 3'd3,
        CFG_TAKEOFF_ALT    = 3'd4,
        CFG_SEARCH_STEP    = 3'd5,
        CFG_ALIGN_WINDOW   = 3'd6
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;

    // Register reset values.
    localparam logic [5:0] RST_ALT_STEP       = 6'd10;
    localparam logic [6:0] RST_ALT_MAX        = 7'd100;
    localparam logic [6:0] RST_ALT_MIN_FLYING = 7'd10;
    localparam logic [6:0] RST_YAW_STEP       = 7'd15;
    localparam logic [6:0] RST_TAKEOFF_ALT    = 7'd5;
    localparam logic [4:0] RST_SEARCH_STEP    = 5'd3;
    localparam logic [4:0] RST_ALIGN_WINDOW   = 5'd2;

    // Heading and altitude constants.
    localparam logic signed [12:0] REF_NOT_FOUND = 13'sd3600;
    localparam logic [6:0]         ALT_CEIL      = 7'd100;
    localparam logic signed [10:0] HEAD_MAX      = 11'sd180;
    localparam logic signed [10:0] HEAD_MIN      = -11'sd180;
    localparam logic signed [10:0] HEAD_TURN     = 11'sd360;
    localparam logic signed [10:0] RIGHT_WRAP_TO = -11'sd165;
    localparam logic signed [10:0] LEFT_WRAP_TO  = 11'sd165;

    // Configuration registers as seen by the update logic.
    typedef struct packed {
        logic [5:0] alt_step;
        logic [6:0] alt_max;
        logic [6:0] alt_min_flying;
        logic [6:0] yaw_step;
        logic [6:0] takeoff_alt;
        logic [4:0] search_step;
        logic [4:0] align_window;
    } t_cfg;

    // One pass word after input conversion.
    typedef struct packed {
        logic              btn_up;
        logic              btn_down;
        logic              btn_right;
        logic              btn_left;
        logic              takeoff_sw;
        logic              alt_zero;
        logic signed [8:0] yaw_deg;
        logic signed [8:0] ref_head;
        logic              ref_found;
        logic              mode_step;
        logic              ramp_step;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/fms_input_stage.sv @@
// ----------------------------------------------------------------------------
// fms_input_stage
// Input register: takes one pass word and converts yaw and reference to
// whole degrees on the way in.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_input_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_btn_up,
    input  wire logic                 i_btn_down,
    input  wire logic                 i_btn_right,
    input  wire logic                 i_btn_left,
    input  wire logic                 i_takeoff_switch,
    input  wire logic [8:0]           i_altitude_pct,
    input  wire logic signed [11:0]   i_yaw_tenths,
    input  wire logic signed [12:0]   i_ref_tenths,
    input  wire logic                 i_mode_step,
    input  wire logic                 i_ramp_step,
    input  wire logic                 i_advance,
    output logic                      o_item_valid,
    output fms_pkg::t_item            o_item
);
    import fms_pkg::*;

    // Divide by ten through a reciprocal multiply, exact for x up to 4096.
    function automatic logic [8:0] div10(input logic [12:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'd52429;
        return p[27:19];
    endfunction

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic              load;
    logic [12:0]       yaw_abs;
    logic [12:0]       ref_abs;
    logic signed [10:0] yaw_q;
    logic signed [10:0] ref_q;
    logic signed [10:0] ref_w;

    assign load       = !r_valid || i_advance;
    assign o_in_stall = !load;

    // Truncating division toward zero on the magnitudes.
    always_comb begin
        yaw_abs = i_yaw_tenths[11] ? 13'(-14'(i_yaw_tenths)) : 13'(i_yaw_tenths);
        ref_abs = i_ref_tenths[12] ? 13'(-14'(i_ref_tenths)) : 13'(i_ref_tenths);
        yaw_q   = i_yaw_tenths[11] ? -$signed({2'b00, div10(yaw_abs)})
                                   : $signed({2'b00, div10(yaw_abs)});
        ref_q   = i_ref_tenths[12] ? -$signed({2'b00, div10(ref_abs)})
                                   : $signed({2'b00, div10(ref_abs)});
        // One turn of wrap brings any 13-bit reference into range.
        if (ref_q > HEAD_MAX) begin
            ref_w = ref_q - HEAD_TURN;
        end else if (ref_q < HEAD_MIN) begin
            ref_w = ref_q + HEAD_TURN;
        end else begin
            ref_w = ref_q;
        end

        n_item.btn_up     = i_btn_up;
        n_item.btn_down   = i_btn_down;
        n_item.btn_right  = i_btn_right;
        n_item.btn_left   = i_btn_left;
        n_item.takeoff_sw = i_takeoff_switch;
        n_item.alt_zero   = (i_altitude_pct == 9'd0);
        n_item.yaw_deg    = yaw_q[8:0];
        n_item.ref_head   = ref_w[8:0];
        n_item.ref_found  = (i_ref_tenths != REF_NOT_FOUND);
        n_item.mode_step  = i_mode_step;
        n_item.ramp_step  = i_ramp_step;
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

@@ rtl/fms_update.sv @@
// ----------------------------------------------------------------------------
// fms_update
// Supervisor state and result register: applies one pass to the mode,
// setpoints and drive enable.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_update (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fms_pkg::t_cfg    i_cfg,
    input  wire logic             i_item_valid,
    input  wire fms_pkg::t_item   i_item,
    input  wire logic             i_out_stall,
    output logic                  o_advance,
    output logic                  o_out_valid,
    output logic [1:0]            o_mode,
    output logic [6:0]            o_target_altitude,
    output logic signed [8:0]     o_target_heading,
    output logic                  o_motors_on
);
    import fms_pkg::*;

    function automatic logic [6:0] cap100(input logic [6:0] v);
        return (v > ALT_CEIL) ? ALT_CEIL : v;
    endfunction

    t_mode             r_mode;
    t_mode             n_mode;
    logic [6:0]        r_alt;
    logic [6:0]        n_alt;
    logic signed [8:0] r_yaw;
    logic signed [8:0] n_yaw;
    logic              r_drive;
    logic              n_drive;
    logic              r_out_valid;

    logic signed [8:0]  a;
    logic signed [8:0]  amax;
    logic signed [8:0]  amin;
    logic signed [8:0]  astep;
    logic signed [10:0] y;
    logic signed [10:0] ys;
    logic signed [10:0] yd;
    logic signed [10:0] win;
    logic signed [10:0] ystep;

    assign o_advance = i_item_valid && (!r_out_valid || !i_out_stall);

    // Next state for one pass: buttons, then mode rules, then the ramp.
    always_comb begin
        amax    = $signed({2'b00, cap100(i_cfg.alt_max)});
        amin    = $signed({2'b00, cap100(i_cfg.alt_min_flying)});
        astep   = $signed({3'b000, i_cfg.alt_step});
        ystep   = $signed({4'b0000, i_cfg.yaw_step});
        win     = $signed({6'b000000, i_cfg.align_window});
        yd      = 11'(i_item.yaw_deg);
        a       = $signed({2'b00, r_alt});
        y       = 11'(r_yaw);
        n_mode  = r_mode;
        n_drive = r_drive;

        // Buttons act only while flying.
        if (r_mode == MODE_FLYING) begin
            if (i_item.btn_up) begin
                a = (a + astep > amax) ? amax : a + astep;
            end
            if (i_item.btn_down) begin
                a = (a - astep < amin) ? amin : a - astep;
            end
            if (i_item.btn_right) begin
                ys = y + ystep;
                y  = (ys > HEAD_MAX) ? RIGHT_WRAP_TO : ys;
            end
            if (i_item.btn_left) begin
                ys = y - ystep;
                y  = (ys <= HEAD_MIN) ? LEFT_WRAP_TO : ys;
            end
        end

        // Mode transition rules.
        if (i_item.mode_step) begin
            case (r_mode)
                MODE_LANDED: begin
                    if (i_item.takeoff_sw) begin
                        n_drive = 1'b1;
                        n_mode  = MODE_TAKEOFF;
                    end
                end
                MODE_LANDING: begin
                    if (i_item.alt_zero && a == 9'sd0) begin
                        n_drive = 1'b0;
                        n_mode  = MODE_LANDED;
                    end
                end
                MODE_TAKEOFF: begin
                    a = $signed({2'b00, cap100(i_cfg.takeoff_alt)});
                    if (i_item.ref_found) begin
                        a      = amin;
                        y      = 11'(i_item.ref_head);
                        n_mode = MODE_FLYING;
                    end
                end
                default: begin
                    if (!i_item.takeoff_sw) begin
                        y      = 11'(i_item.ref_head);
                        n_mode = MODE_LANDING;
                    end
                end
            endcase
        end

        // Slow search in takeoff and descent in landing.
        if (i_item.ramp_step) begin
            if (!i_item.ref_found && n_mode == MODE_TAKEOFF) begin
                ys = y + $signed({6'b000000, i_cfg.search_step});
                y  = (ys > HEAD_MAX) ? ys - HEAD_TURN : ys;
            end
            if (n_mode == MODE_LANDING) begin
                if (yd < y + win && yd > y - win && a > 9'sd0) begin
                    a = a - 9'sd1;
                end
            end
        end

        ys    = 11'sd0;
        n_alt = a[6:0];
        n_yaw = y[8:0];
    end

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LANDED;
        end else if (o_advance) begin
            r_mode <= n_mode;
        end
    end

    // Setpoints, drive enable and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt       <= 7'd0;
            r_yaw       <= 9'sd0;
            r_drive     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_alt   <= n_alt;
                r_yaw   <= n_yaw;
                r_drive <= n_drive;
            end
            if (o_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mode            = r_mode;
    assign o_target_altitude = r_alt;
    assign o_target_heading  = r_yaw;
    assign o_motors_on       = r_drive;

endmodule

`default_nettype wire

@@ rtl/flight_mode_supervisor.sv @@
// ----------------------------------------------------------------------------
// flight_mode_supervisor
// Mode supervisor for a small helicopter rig: mode, altitude and heading
// setpoints and motor enable, updated once per supervisor pass.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       i_in_valid/o_in_stall  buttons, switch, altitude, yaw, reference,
//                                  mode and ramp step flags
//  out      o_out_valid/i_out_stall mode, target altitude, heading, motors on
//  cfg      i_cfg_we               i_cfg_index, i_cfg_data
//
// One pass word is taken per cycle while o_in_stall is low. A taken word
// sits in the input register and then updates the state register, whose
// outputs carry its result. The state register doubles as the result
// register, so a stalled result holds the waiting word in the input
// register, which then stalls the input.
// Reset is synchronous: it clears the mode, setpoints, drive enable and
// registers to their defaults.
`default_nettype none

module flight_mode_supervisor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_btn_up,
    input  wire logic                          i_btn_down,
    input  wire logic                          i_btn_right,
    input  wire logic                          i_btn_left,
    input  wire logic                          i_takeoff_switch,
    input  wire logic [8:0]                    i_altitude_pct,
    input  wire logic signed [11:0]            i_yaw_tenths,
    input  wire logic signed [12:0]            i_ref_tenths,
    input  wire logic                          i_mode_step,
    input  wire logic                          i_ramp_step,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_mode,
    output logic [6:0]                         o_target_altitude,
    output logic signed [8:0]                  o_target_heading,
    output logic                               o_motors_on,
    input  wire logic                          i_cfg_we,
    input  wire logic [fms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fms_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fms_pkg::*;

    t_cfg  r_cfg;
    t_item item;
    logic  item_valid;
    logic  advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alt_step       <= RST_ALT_STEP;
            r_cfg.alt_max        <= RST_ALT_MAX;
            r_cfg.alt_min_flying <= RST_ALT_MIN_FLYING;
            r_cfg.yaw_step       <= RST_YAW_STEP;
            r_cfg.takeoff_alt    <= RST_TAKEOFF_ALT;
            r_cfg.search_step    <= RST_SEARCH_STEP;
            r_cfg.align_window   <= RST_ALIGN_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALT_STEP:       r_cfg.alt_step       <= i_cfg_data[5:0];
                CFG_ALT_MAX:        r_cfg.alt_max        <= i_cfg_data[6:0];
                CFG_ALT_MIN_FLYING: r_cfg.alt_min_flying <= i_cfg_data[6:0];
                CFG_YAW_STEP:       r_cfg.yaw_step       <= i_cfg_data[6:0];
                CFG_TAKEOFF_ALT:    r_cfg.takeoff_alt    <= i_cfg_data[6:0];
                CFG_SEARCH_STEP:    r_cfg.search_step    <= i_cfg_data[4:0];
                CFG_ALIGN_WINDOW:   r_cfg.align_window   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // The step flags travel in the input register beside the converted word.
    fms_input_stage u_input (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_btn_up         (i_btn_up),
        .i_btn_down       (i_btn_down),
        .i_btn_right      (i_btn_right),
        .i_btn_left       (i_btn_left),
        .i_takeoff_switch (i_takeoff_switch),
        .i_altitude_pct   (i_altitude_pct),
        .i_yaw_tenths     (i_yaw_tenths),
        .i_ref_tenths     (i_ref_tenths),
        .i_mode_step      (i_mode_step),
        .i_ramp_step      (i_ramp_step),
        .i_advance        (advance),
        .o_item_valid     (item_valid),
        .o_item           (item)
    );

    fms_update u_update (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_item_valid      (item_valid),
        .i_item            (item),
        .i_out_stall       (i_out_stall),
        .o_advance         (advance),
        .o_out_valid       (o_out_valid),
        .o_mode            (o_mode),
        .o_target_altitude (o_target_altitude),
        .o_target_heading  (o_target_heading),
        .o_motors_on       (o_motors_on)
    );

endmodule

`default_nettype wire
